// ----- hw/rtl/tbba_pkg.sv -----
// Shared types and constants for the transformed bounding box accumulator.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps
package tbba_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;
  localparam int COEF_WIDTH  = 16;
  localparam int NUM_AXES    = 3;
  localparam int ROW_WIDTH   = 4 * COEF_WIDTH;
  localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;

  localparam int DATA_WIDTH  = 64;
  localparam int ADDR_WIDTH  = 5;
  localparam int REG_IDX_LSB = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        extent_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic [ROW_WIDTH-1:0]          coef_row_t;
  typedef coord_t [NUM_AXES-1:0]         point_t;
  typedef extent_t [NUM_AXES-1:0]        extent_vec_t;

  typedef enum logic [1:0] {
    REG_ROW_X = 2'd0,
    REG_ROW_Y = 2'd1,
    REG_ROW_Z = 2'd2
  } reg_idx_t;

  localparam coef_row_t ROW_X_RESET = coef_row_t'(64'h100);
  localparam coef_row_t ROW_Y_RESET = coef_row_t'(64'h100) << COEF_WIDTH;
  localparam coef_row_t ROW_Z_RESET = coef_row_t'(64'h100) << (2 * COEF_WIDTH);

  localparam coord_t COORD_MAX_C = coord_t'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
  localparam coord_t COORD_MIN_C = coord_t'(64'd1 << (COORD_WIDTH - 1));

  typedef struct packed {
    point_t lo;
    point_t hi;
  } box_t;

  typedef struct packed {
    point_t      lo;
    point_t      hi;
    point_t      center;
    extent_vec_t extent;
  } result_t;

endpackage

// ----- hw/rtl/tbba_if.sv -----
// Stream interfaces for point transactions in and box transactions out.
// Depends on tbba_pkg.
`timescale 1ns / 1ps
interface tbba_in_if;
  import tbba_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  coord_t point_z;
  logic   last_point;
  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface tbba_out_if;
  import tbba_pkg::*;
  logic    valid;
  logic    ready;
  coord_t  min_x;
  coord_t  min_y;
  coord_t  min_z;
  coord_t  max_x;
  coord_t  max_y;
  coord_t  max_z;
  coord_t  center_x;
  coord_t  center_y;
  coord_t  center_z;
  extent_t extent_x;
  extent_t extent_y;
  extent_t extent_z;
  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  input ready);
  modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  output ready);
endinterface

// ----- hw/rtl/transformed_bounding_box_accumulator_core.sv -----
// Top level: register file, transform pipeline, box accumulator and result stage.
// Depends on tbba_pkg, tbba_if, tbba_xform, tbba_accum, tbba_result.
//
// Channel   Direction  Transaction
// in_chan   sink       one 3-D point, last_point closes the set
// out_chan  source     box min/max corners, center and extents per set
// psel/...  APB slave  64-bit coefficient rows at 0x00, 0x08, 0x10
//
// One point per cycle unless a last point waits on a stalled box; a result
// passes the input, product, sum and box registers, then the result register.
// Reset (rst_n low, synchronous) loads the identity matrix and clears the box.
// A stalled result holds only the box and result registers; points that do not
// close a set keep flowing and stall only behind a second finished box.
`timescale 1ns / 1ps
module transformed_bounding_box_accumulator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  tbba_in_if.sink                         in_chan,
  tbba_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbba_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [tbba_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [tbba_pkg::DATA_WIDTH-1:0] prdata,
  output logic                            pready
);
  import tbba_pkg::*;

  coef_row_t [NUM_AXES-1:0] rows_r;
  reg_idx_t                 reg_idx;
  point_t                   in_pt;
  logic                     t_valid, t_ready, t_last;
  point_t                   t_pt;
  logic                     box_valid, box_ready;
  box_t                     box;
  result_t                  res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[REG_IDX_LSB +: 2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[REG_ROW_X] <= ROW_X_RESET;
      rows_r[REG_ROW_Y] <= ROW_Y_RESET;
      rows_r[REG_ROW_Z] <= ROW_Z_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ROW_X: rows_r[REG_ROW_X] <= pwdata;
        REG_ROW_Y: rows_r[REG_ROW_Y] <= pwdata;
        REG_ROW_Z: rows_r[REG_ROW_Z] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_X: prdata = rows_r[REG_ROW_X];
      REG_ROW_Y: prdata = rows_r[REG_ROW_Y];
      REG_ROW_Z: prdata = rows_r[REG_ROW_Z];
      default:   prdata = '0;
    endcase
  end

  assign in_pt[0] = in_chan.point_x;
  assign in_pt[1] = in_chan.point_y;
  assign in_pt[2] = in_chan.point_z;

  tbba_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_pt    (in_pt),
    .in_last  (in_chan.last_point),
    .rows     (rows_r),
    .t_valid  (t_valid),
    .t_ready  (t_ready),
    .t_pt     (t_pt),
    .t_last   (t_last)
  );

  tbba_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .t_valid   (t_valid),
    .t_ready   (t_ready),
    .t_pt      (t_pt),
    .t_last    (t_last),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box)
  );

  tbba_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box_valid),
    .box_ready (box_ready),
    .box       (box),
    .res_valid (out_chan.valid),
    .res_ready (out_chan.ready),
    .res       (res)
  );

  assign out_chan.min_x    = res.lo[0];
  assign out_chan.min_y    = res.lo[1];
  assign out_chan.min_z    = res.lo[2];
  assign out_chan.max_x    = res.hi[0];
  assign out_chan.max_y    = res.hi[1];
  assign out_chan.max_z    = res.hi[2];
  assign out_chan.center_x = res.center[0];
  assign out_chan.center_y = res.center[1];
  assign out_chan.center_z = res.center[2];
  assign out_chan.extent_x = res.extent[0];
  assign out_chan.extent_y = res.extent[1];
  assign out_chan.extent_z = res.extent[2];

  // a finished box always holds at least one point
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    box_valid |-> ($signed(box.lo[0]) <= $signed(box.hi[0])) &&
                  ($signed(box.lo[1]) <= $signed(box.hi[1])) &&
                  ($signed(box.lo[2]) <= $signed(box.hi[2])))
    else $error("finished box has min above max");

  a_box_held: assert property (@(posedge clk) disable iff (!rst_n)
    box_valid && !box_ready |=> box_valid && $stable(box))
    else $error("pending box lost or changed while result stage stalled");

  a_center_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      ($signed(res.center[0]) >= $signed(res.lo[0])) &&
      ($signed(res.center[0]) <= $signed(res.hi[0])) &&
      ($signed(res.center[1]) >= $signed(res.lo[1])) &&
      ($signed(res.center[1]) <= $signed(res.hi[1])) &&
      ($signed(res.center[2]) >= $signed(res.lo[2])) &&
      ($signed(res.center[2]) <= $signed(res.hi[2])))
    else $error("center outside box");
endmodule

// ----- hw/rtl/tbba_xform.sv -----
// Input register, product stage and sum/round/saturate stage of the affine transform.
// Depends on tbba_pkg.
`timescale 1ns / 1ps
module tbba_xform (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tbba_pkg::point_t                 in_pt,
  input  logic                             in_last,
  input  tbba_pkg::coef_row_t [tbba_pkg::NUM_AXES-1:0] rows,
  output logic                             t_valid,
  input  logic                             t_ready,
  output tbba_pkg::point_t                 t_pt,
  output logic                             t_last
);
  import tbba_pkg::*;

  localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
    (FRAC_BITS == 0) ? '0 : SUM_WIDTH'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = SUM_WIDTH'(COORD_MAX_C);
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = SUM_WIDTH'(COORD_MIN_C);

  logic                          s1_v_r, s2_v_r, s3_v_r;
  point_t                        s1_pt_r;
  logic                          s1_last_r, s2_last_r, s3_last_r;
  logic signed [PROD_WIDTH-1:0]  prod_r [NUM_AXES][NUM_AXES];
  coef_t                         off_r  [NUM_AXES];
  point_t                        s3_pt_r;
  point_t                        sat_nxt;
  logic signed [SUM_WIDTH-1:0]   sum    [NUM_AXES];
  logic signed [SUM_WIDTH-1:0]   shr    [NUM_AXES];
  logic                          s2_en, s3_en;

  assign s3_en    = !s3_v_r || t_ready;
  assign s2_en    = !s2_v_r || s3_en;
  assign in_ready = !s1_v_r || s2_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (s2_en)    s2_v_r <= s1_v_r;
      if (s3_en)    s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pt_r   <= in_pt;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      s2_last_r <= s1_last_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          prod_r[a][k] <= PROD_WIDTH'($signed(rows[a][k*COEF_WIDTH +: COEF_WIDTH]) *
                                      $signed(s1_pt_r[k]));
        end
        off_r[a] <= $signed(rows[a][NUM_AXES*COEF_WIDTH +: COEF_WIDTH]);
      end
    end
  end

  // floor((sum + half) >> FRAC_BITS), then clamp to the coordinate range
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum[a] = SUM_WIDTH'(prod_r[a][0]) + SUM_WIDTH'(prod_r[a][1]) +
               SUM_WIDTH'(prod_r[a][2]) + (SUM_WIDTH'(off_r[a]) <<< FRAC_BITS) + ROUND_HALF;
      shr[a] = sum[a] >>> FRAC_BITS;
      if (shr[a] > SUM_MAX) begin
        sat_nxt[a] = COORD_MAX_C;
      end else if (shr[a] < SUM_MIN) begin
        sat_nxt[a] = COORD_MIN_C;
      end else begin
        sat_nxt[a] = shr[a][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_v_r) begin
      s3_pt_r   <= sat_nxt;
      s3_last_r <= s2_last_r;
    end
  end

  assign t_valid = s3_v_r;
  assign t_pt    = s3_pt_r;
  assign t_last  = s3_last_r;
endmodule

// ----- hw/rtl/tbba_accum.sv -----
// Running per-axis min/max; hands off the finished box on the last point of a set.
// Depends on tbba_pkg.
`timescale 1ns / 1ps
module tbba_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             t_valid,
  output logic             t_ready,
  input  tbba_pkg::point_t t_pt,
  input  logic             t_last,
  output logic             box_valid,
  input  logic             box_ready,
  output tbba_pkg::box_t   box
);
  import tbba_pkg::*;

  point_t run_min_r, run_max_r;
  point_t min_nxt, max_nxt;
  logic   box_v_r;
  box_t   box_r;
  logic   take;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      min_nxt[a] = ($signed(t_pt[a]) < $signed(run_min_r[a])) ? t_pt[a] : run_min_r[a];
      max_nxt[a] = ($signed(t_pt[a]) > $signed(run_max_r[a])) ? t_pt[a] : run_max_r[a];
    end
  end

  // non-last points never wait on the box register
  assign t_ready = !t_last || !box_v_r || box_ready;
  assign take    = t_valid && t_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= {NUM_AXES{COORD_MAX_C}};
      run_max_r <= {NUM_AXES{COORD_MIN_C}};
      box_v_r   <= 1'b0;
    end else begin
      if (take && t_last) begin
        run_min_r <= {NUM_AXES{COORD_MAX_C}};
        run_max_r <= {NUM_AXES{COORD_MIN_C}};
        box_v_r   <= 1'b1;
      end else begin
        if (take) begin
          run_min_r <= min_nxt;
          run_max_r <= max_nxt;
        end
        if (box_ready) box_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && t_last) begin
      box_r.lo <= min_nxt;
      box_r.hi <= max_nxt;
    end
  end

  assign box_valid = box_v_r;
  assign box       = box_r;
endmodule

// ----- hw/rtl/tbba_result.sv -----
// Center and extent computation feeding the result output register.
// Depends on tbba_pkg.
`timescale 1ns / 1ps
module tbba_result (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              box_valid,
  output logic              box_ready,
  input  tbba_pkg::box_t    box,
  output logic              res_valid,
  input  logic              res_ready,
  output tbba_pkg::result_t res
);
  import tbba_pkg::*;

  logic                        res_v_r;
  result_t                     res_r;
  result_t                     res_nxt;
  logic signed [COORD_WIDTH:0] mid_sum [NUM_AXES];

  always_comb begin
    res_nxt.lo = box.lo;
    res_nxt.hi = box.hi;
    for (int a = 0; a < NUM_AXES; a++) begin
      mid_sum[a]       = (COORD_WIDTH+1)'($signed(box.lo[a])) +
                         (COORD_WIDTH+1)'($signed(box.hi[a]));
      res_nxt.center[a] = mid_sum[a][COORD_WIDTH:1];
      res_nxt.extent[a] = extent_t'(box.hi[a] - res_nxt.center[a]);
    end
  end

  assign box_ready = !res_v_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (box_ready) begin
      res_v_r <= box_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (box_ready && box_valid) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;
endmodule
